/* rtl/egcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_pkg: shared types for the extended gcd unit
// Holds the status flags that the shared shift-subtract unit reports to
// the sequencer.
// ----------------------------------------------------------------------------
package egcd_pkg;

  // Compare results of the shift-subtract unit.
  typedef struct packed {
    logic ge;        // shifted divisor fits under the partial remainder
    logic next_fits; // divisor shifted one place further still fits
  } egcd_flags_t;

endpackage : egcd_pkg
`default_nettype wire

/* rtl/egcd_step_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_step_unit: shared shift, compare and subtract unit
// Forms the divisor and its coefficients shifted left by the current
// quotient bit position, compares against the partial remainder and gives
// the differences for a conditional subtraction.
// ----------------------------------------------------------------------------
module egcd_step_unit
  import egcd_pkg::*;
#(
  parameter int DATA_WIDTH = 31,
  parameter int COEF_WIDTH = 32,
  parameter int SHIFT_WIDTH = 5
) (
  input  wire logic [SHIFT_WIDTH-1:0] shift,
  input  wire logic [DATA_WIDTH-1:0]  rem_in,
  input  wire logic [DATA_WIDTH-1:0]  div_in,
  input  wire logic [COEF_WIDTH-1:0]  s_rem,
  input  wire logic [COEF_WIDTH-1:0]  s_div,
  input  wire logic [COEF_WIDTH-1:0]  t_rem,
  input  wire logic [COEF_WIDTH-1:0]  t_div,
  output logic      [DATA_WIDTH-1:0]  rem_diff,
  output logic      [COEF_WIDTH-1:0]  s_diff,
  output logic      [COEF_WIDTH-1:0]  t_diff,
  output egcd_flags_t                 flags
);

  logic [DATA_WIDTH:0]    div_sh;
  logic [DATA_WIDTH:0]    div_sh_next;
  logic [SHIFT_WIDTH:0]   shift_p1;
  logic [COEF_WIDTH-1:0]  s_sh;
  logic [COEF_WIDTH-1:0]  t_sh;

  // Shifted divisor at this and the next bit position. While the sequencer
  // keeps the shifted divisor at or below the remainder, one extra bit of
  // width holds the next position without loss.
  assign shift_p1    = {1'b0, shift} + (SHIFT_WIDTH + 1)'(1);
  assign div_sh      = {1'b0, div_in} << shift;
  assign div_sh_next = {1'b0, div_in} << shift_p1;

  // Coefficients follow the divisor; they wrap in two's complement.
  assign s_sh = s_div << shift;
  assign t_sh = t_div << shift;

  // Compare and subtract.
  assign flags.ge        = (div_sh <= {1'b0, rem_in});
  assign flags.next_fits = (div_sh_next <= {1'b0, rem_in});
  assign rem_diff        = rem_in - div_sh[DATA_WIDTH-1:0];
  assign s_diff          = s_rem - s_sh;
  assign t_diff          = t_rem - t_sh;

endmodule : egcd_step_unit
`default_nettype wire

/* rtl/extended_gcd_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// extended_gcd_unit: extended Euclidean algorithm
// Returns the gcd of two unsigned operands and the Bezout coefficients
// that multiply each operand to give it.
// ----------------------------------------------------------------------------
// A transfer is accepted on a clock edge with start high and busy low. The
// unit then stays busy and, when finished, presents gcd_value, coef_a and
// coef_b for exactly one cycle with done high; the receiver must take them
// then, as they are not held. For every Euclid step, a single
// shift-compare-subtract unit first aligns the divisor to the remainder
// one bit a cycle and then produces one quotient bit a cycle, updating
// both coefficients as it goes. A new start may be given in the cycle
// that done is high.
// ----------------------------------------------------------------------------
module extended_gcd_unit
  import egcd_pkg::*;
#(
  parameter int DATA_WIDTH = 31
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [DATA_WIDTH-1:0]   operand_a,
  input  wire logic [DATA_WIDTH-1:0]   operand_b,
  output logic                         busy,
  output logic                         done,
  output logic      [DATA_WIDTH-1:0]   gcd_value,
  output logic signed [DATA_WIDTH:0]   coef_a,
  output logic signed [DATA_WIDTH:0]   coef_b
);

  localparam int CW = DATA_WIDTH + 1;
  localparam int KW = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_ALIGN,
    S_SUB
  } state_t;

  state_t              state;
  logic                swapped;
  logic [DATA_WIDTH-1:0] r0;
  logic [DATA_WIDTH-1:0] r1;
  logic [CW-1:0]       s0;
  logic [CW-1:0]       s1;
  logic [CW-1:0]       t0;
  logic [CW-1:0]       t1;
  logic [KW-1:0]       k;

  logic [DATA_WIDTH-1:0] rem_diff;
  logic [CW-1:0]       s_diff;
  logic [CW-1:0]       t_diff;
  egcd_flags_t         flags;

  // Shared shift-compare-subtract unit.
  egcd_step_unit #(
    .DATA_WIDTH  (DATA_WIDTH),
    .COEF_WIDTH  (CW),
    .SHIFT_WIDTH (KW)
  ) u_step (
    .shift    (k),
    .rem_in   (r0),
    .div_in   (r1),
    .s_rem    (s0),
    .s_div    (s1),
    .t_rem    (t0),
    .t_div    (t1),
    .rem_diff (rem_diff),
    .s_diff   (s_diff),
    .t_diff   (t_diff),
    .flags    (flags)
  );

  assign busy = (state != S_IDLE);

  // Sequencer: order the pair, then repeat align and subtract passes until
  // the remainder is zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            swapped <= (operand_a < operand_b);
            r0      <= (operand_a < operand_b) ? operand_b : operand_a;
            r1      <= (operand_a < operand_b) ? operand_a : operand_b;
            s0      <= CW'(1);
            s1      <= '0;
            t0      <= '0;
            t1      <= CW'(1);
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (r1 == '0) begin
            gcd_value <= r0;
            coef_a    <= swapped ? t0 : s0;
            coef_b    <= swapped ? s0 : t0;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            k     <= '0;
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          // Shift the divisor up while it still fits under the remainder.
          if (flags.next_fits) begin
            k <= k + KW'(1);
          end else begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (k == '0) begin
            // Last quotient bit: rotate the remainder and coefficient pairs.
            r0    <= r1;
            r1    <= flags.ge ? rem_diff : r0;
            s0    <= s1;
            s1    <= flags.ge ? s_diff : s0;
            t0    <= t1;
            t1    <= flags.ge ? t_diff : t0;
            state <= S_CHECK;
          end else begin
            if (flags.ge) begin
              r0 <= rem_diff;
              s0 <= s_diff;
              t0 <= t_diff;
            end
            k <= k - KW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result strobe lasts one cycle only.
  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // The pair stays ordered larger first at every Euclid step.
  a_order : assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (r0 >= r1))
    else $error("remainder pair out of order");

  // The shifted divisor never exceeds the remainder while aligning.
  a_div_fits : assert property (@(posedge clk) disable iff (rst)
    (state == S_ALIGN) |-> (flags.ge && (r1 != '0)))
    else $error("shifted divisor above remainder");

  // Work starts only on an accepted transfer.
  a_start : assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

endmodule : extended_gcd_unit
`default_nettype wire

/* dv/extended_gcd_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_unit_test: self-checking bench for the extended gcd unit
// Drives operand pairs through the start/busy handshake and checks every
// done strobe against a software model of the extended Euclidean algorithm,
// or typed rows against their own answer. A short table of corner cases
// comes first, then random pairs in several phases of sender idling.
// ----------------------------------------------------------------------------
module extended_gcd_unit_test;

  localparam int          DATA_WIDTH   = 31;
  localparam int          RANDOM_ITEMS = 1150;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          CYCLE_LIMIT  = 3_000_000;
  localparam int          N_DIRECTED   = 20;
  localparam logic [30:0] OP_MAX       = 31'h7FFF_FFFF;
  localparam logic [30:0] FIB_45       = 31'd1134903170;
  localparam logic [30:0] FIB_46       = 31'd1836311903;

  // One result of the unit: gcd and the coefficient of each operand.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] gcd;
    logic [DATA_WIDTH:0]   coef_a;
    logic [DATA_WIDTH:0]   coef_b;
  } gcd_result_t;

  // One row of the corner-case table; typed rows carry their own answer.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic                  typed;
    gcd_result_t           want;
  } gcd_case_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic [DATA_WIDTH-1:0] operand_a;
  logic [DATA_WIDTH-1:0] operand_b;
  logic                  busy;
  logic                  done;
  logic [DATA_WIDTH-1:0] gcd_value;
  logic signed [DATA_WIDTH:0] coef_a;
  logic signed [DATA_WIDTH:0] coef_b;

  gcd_result_t next_result;
  gcd_result_t pending_results [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          idle_pct;

  gcd_case_t corner_cases [N_DIRECTED] = '{
    '{31'd0,       31'd0,       1'b1, '{31'd0,     32'sd1, 32'sd0}},
    '{31'd0,       OP_MAX,      1'b1, '{OP_MAX,    32'sd0, 32'sd1}},
    '{OP_MAX,      31'd0,       1'b1, '{OP_MAX,    32'sd1, 32'sd0}},
    '{31'd1,       31'd0,       1'b1, '{31'd1,     32'sd1, 32'sd0}},
    '{31'd0,       31'd1,       1'b1, '{31'd1,     32'sd0, 32'sd1}},
    '{OP_MAX,      OP_MAX,      1'b1, '{OP_MAX,    32'sd0, 32'sd1}},
    '{31'd1,       31'd1,       1'b1, '{31'd1,     32'sd0, 32'sd1}},
    '{31'd12345,   31'd12345,   1'b1, '{31'd12345, 32'sd0, 32'sd1}},
    '{OP_MAX,      31'd1,       1'b0, '0},
    '{31'd1,       OP_MAX,      1'b0, '0},
    '{OP_MAX,      OP_MAX - 1,  1'b0, '0},
    '{OP_MAX - 1,  OP_MAX,      1'b0, '0},
    '{FIB_46,      FIB_45,      1'b0, '0},
    '{FIB_45,      FIB_46,      1'b0, '0},
    '{OP_MAX,      31'h4000_0000, 1'b0, '0},
    '{31'h4000_0000, 31'h2000_0000, 1'b0, '0},
    '{31'd6,       31'd4,       1'b0, '0},
    '{31'd4,       31'd6,       1'b0, '0},
    '{31'h5555_5555, 31'h2AAA_AAAA, 1'b0, '0},
    '{OP_MAX - 1,  31'd2,       1'b0, '0}
  };

  extended_gcd_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .busy     (busy),
    .done     (done),
    .gcd_value(gcd_value),
    .coef_a   (coef_a),
    .coef_b   (coef_b)
  );

  // Free-running clock, 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Extended Euclid with the coefficients kept modulo 2^64, then each
  // coefficient is reported against its own operand.
  function automatic gcd_result_t compute_bezout(input logic [DATA_WIDTH-1:0] a,
                                                 input logic [DATA_WIDTH-1:0] b);
    bit [63:0]   r0, r1, r2, s0, s1, s2, t0, t1, t2, q;
    bit          swapped;
    gcd_result_t res;
    swapped = a < b;
    r0 = swapped ? 64'(b) : 64'(a);
    r1 = swapped ? 64'(a) : 64'(b);
    s0 = 64'd1;
    s1 = 64'd0;
    t0 = 64'd0;
    t1 = 64'd1;
    while (r1 != 64'd0) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      s2 = s0 - q * s1;
      t2 = t0 - q * t1;
      r0 = r1;
      r1 = r2;
      s0 = s1;
      s1 = s2;
      t0 = t1;
      t1 = t2;
    end
    res.gcd = r0[DATA_WIDTH-1:0];
    if (swapped) begin
      res.coef_a = t0[DATA_WIDTH:0];
      res.coef_b = s0[DATA_WIDTH:0];
    end else begin
      res.coef_a = s0[DATA_WIDTH:0];
      res.coef_b = t0[DATA_WIDTH:0];
    end
    return res;
  endfunction

  // Present one operand pair after a random idle gap and hold it until the
  // unit takes the transfer.
  task automatic issue_operands(input logic [DATA_WIDTH-1:0] a,
                                input logic [DATA_WIDTH-1:0] b,
                                input logic typed, input gcd_result_t want);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      // Now and then a long gap, so that start rises late in a busy stretch.
      if ($urandom_range(9) == 0) begin
        gap = $urandom_range(260, 1);
      end else begin
        gap = 1;
        while ($urandom_range(99) < idle_pct) gap++;
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    operand_a   <= a;
    operand_b   <= b;
    next_result <= typed ? want : compute_bezout(a, b);
    do @(posedge clk); while (busy);
  endtask

  // Random operand pair, biased towards the interesting shapes.
  task automatic pick_operands(output logic [DATA_WIDTH-1:0] a,
                               output logic [DATA_WIDTH-1:0] b);
    logic [31:0] x, y, t;
    int          n;
    case ($urandom_range(9))
      0, 1, 2: begin
        a = DATA_WIDTH'($urandom());
        b = DATA_WIDTH'($urandom());
      end
      3: begin
        a = DATA_WIDTH'($urandom_range(255));
        b = DATA_WIDTH'($urandom_range(255));
      end
      4: begin
        a = DATA_WIDTH'($urandom());
        b = '0;
      end
      5: begin
        a = DATA_WIDTH'($urandom()) >> $urandom_range(30);
        b = a;
      end
      6: begin
        b = DATA_WIDTH'($urandom_range(65535, 1));
        a = DATA_WIDTH'(b * $urandom_range(32767, 1));
      end
      7: begin
        a = DATA_WIDTH'($urandom());
        b = DATA_WIDTH'($urandom_range(1023, 1));
      end
      8: begin
        a = DATA_WIDTH'($urandom()) >> $urandom_range(30);
        b = DATA_WIDTH'($urandom()) >> $urandom_range(30);
      end
      default: begin
        // Consecutive Fibonacci numbers give the longest step chains.
        x = 32'd0;
        y = 32'd1;
        n = $urandom_range(45, 2);
        repeat (n) begin
          t = x + y;
          x = y;
          y = t;
        end
        a = DATA_WIDTH'(y);
        b = DATA_WIDTH'(x);
      end
    endcase
    if ($urandom_range(1)) begin
      {a, b} = {b, a};
    end
  endtask

  // Compare each done strobe with the oldest outstanding expectation, then
  // record any transfer taken at this edge.
  always @(posedge clk) begin : check_results
    gcd_result_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result with no transfer outstanding: gcd_value %0d", gcd_value);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (gcd_value !== want.gcd) begin
            $error("gcd_value: expected %0d, actual %0d", want.gcd, gcd_value);
            error_count++;
          end
          if (coef_a !== want.coef_a) begin
            $error("coef_a: expected %0d, actual %0d", $signed(want.coef_a), coef_a);
            error_count++;
          end
          if (coef_b !== want.coef_b) begin
            $error("coef_b: expected %0d, actual %0d", $signed(want.coef_b), coef_b);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(next_result);
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("extended_gcd_unit_test NOT OK");
      $finish;
    end
  end

  // Stimulus: reset, corner cases, then random phases of sender idling.
  initial begin : stimulus
    int                    phase_pct [4] = '{0, 65, 0, 28};
    logic [DATA_WIDTH-1:0] a, b;
    rst         = 1'b1;
    start       = 1'b0;
    operand_a   = '0;
    operand_b   = '0;
    next_result = '0;
    idle_pct    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_cases[i]) begin
      issue_operands(corner_cases[i].a, corner_cases[i].b,
                     corner_cases[i].typed, corner_cases[i].want);
    end

    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      repeat (RANDOM_ITEMS / 4) begin
        pick_operands(a, b);
        issue_operands(a, b, 1'b0, '0);
      end
    end
    start <= 1'b0;

    // Let the last results arrive, then watch for stray strobes.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
    end

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("extended_gcd_unit_test OK");
    end else begin
      $display("extended_gcd_unit_test NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/egcd_pkg.sv
rtl/egcd_step_unit.sv
rtl/extended_gcd_unit.sv
dv/extended_gcd_unit_test.sv
